### rtl/core/argb_pixel_compositor_assert.svh
// Assertion macros for the pixel compositor.
// ASSERT_IMPLIES checks a consequent in the same cycle, ASSERT_NEXT in the following cycle.
`ifndef ARGB_PIXEL_COMPOSITOR_ASSERT_SVH
`define ARGB_PIXEL_COMPOSITOR_ASSERT_SVH

`ifndef SYNTHESIS
`define APC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define APC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define APC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define APC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### rtl/core/apc_pkg.sv
package apc_pkg;

   // Blend mode codes
   typedef enum logic [1:0] {
      MODE_COPY    = 2'd0,
      MODE_ALPHA   = 2'd1,
      MODE_OPACITY = 2'd2,
      MODE_TINT    = 2'd3
   } apc_mode_type;

   // Configuration register indexes
   localparam logic REG_OPACITY = 1'b0;
   localparam logic REG_TINT    = 1'b1;

   localparam logic [7:0]  OPACITY_RESET = 8'hFF;
   localparam logic [23:0] TINT_RESET    = 24'h000000;
   localparam logic [15:0] ROUND_BIAS    = 16'd128;
   localparam logic [7:0]  ALPHA_FULL    = 8'hFF;

   // Word after the alpha stages: blend factor and operands
   typedef struct packed {
      logic        written;
      logic [7:0]  alpha;
      logic [23:0] color;
      logic [31:0] dest;
   } apc_mix_type;

   // Word after the product stage: per-channel rounded sums (R, G, B)
   typedef struct packed {
      logic             written;
      logic [2:0][15:0] sum;
      logic [31:0]      dest;
   } apc_sum_type;

   // Exact rounded divide by 255 of a biased 16-bit sum
   function automatic logic [7:0] apc_div255(input logic [15:0] t);
      logic [16:0] s;
      begin
         s = {1'b0, t} + {9'b0, t[15:8]};
         return s[15:8];
      end
   endfunction

endpackage

### rtl/core/apc_req_if.sv
interface apc_req_if import apc_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] source_pixel;
   logic [31:0] dest_pixel;

   modport source (output valid, output mode, output source_pixel, output dest_pixel,
                   input ready);
   modport sink   (input valid, input mode, input source_pixel, input dest_pixel,
                   output ready);
endinterface

### rtl/core/apc_rsp_if.sv
interface apc_rsp_if import apc_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [31:0] result_pixel;
   logic        written;

   modport source (output valid, output result_pixel, output written, input ready);
   modport sink   (input valid, input result_pixel, input written, output ready);
endinterface

### rtl/core/apc_alpha.sv
module apc_alpha import apc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   apc_req_if.sink     req_chan,
   input  logic [7:0]  opacity,
   input  logic [23:0] tint_color,
   output logic        out_valid,
   input  logic        out_ready,
   output apc_mix_type out_word
);

   logic         s1_valid_ff, s1_valid_in;
   apc_mode_type s1_mode_ff;
   logic [7:0]   s1_alpha_ff;
   logic [15:0]  s1_prod_ff, s1_prod_in;
   logic [23:0]  s1_color_ff, s1_color_in;
   logic [31:0]  s1_dest_ff;
   logic         s2_valid_ff, s2_valid_in;
   apc_mix_type  s2_word_ff, s2_word_in;
   logic         s1_en, s2_en;
   logic [7:0]   s2_alpha;

   // stage enables collapse bubbles
   assign s2_en          = !s2_valid_ff || out_ready;
   assign s1_en          = !s1_valid_ff || s2_en;
   assign req_chan.ready = s1_en;

   // stage 1: opacity product and color select
   always_comb begin
      s1_valid_in = req_chan.valid;
      s1_prod_in  = ({8'b0, req_chan.source_pixel[31:24]} * {8'b0, opacity}) + ROUND_BIAS;
      case (apc_mode_type'(req_chan.mode))
         MODE_TINT: s1_color_in = tint_color;
         default:   s1_color_in = req_chan.source_pixel[23:0];
      endcase
   end

   // stage 2: blend factor per mode; zero factor means skip
   always_comb begin
      case (s1_mode_ff)
         MODE_COPY:    s2_alpha = ALPHA_FULL;
         MODE_OPACITY: s2_alpha = apc_div255(s1_prod_ff);
         default:      s2_alpha = s1_alpha_ff;
      endcase
      s2_valid_in        = s1_valid_ff;
      s2_word_in.written = (s2_alpha != 8'd0);
      s2_word_in.alpha   = s2_alpha;
      s2_word_in.color   = s1_color_ff;
      s2_word_in.dest    = s1_dest_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_en) s1_valid_ff <= s1_valid_in;
         if (s2_en) s2_valid_ff <= s2_valid_in;
      end
      if (s1_en) begin
         s1_mode_ff  <= apc_mode_type'(req_chan.mode);
         s1_alpha_ff <= req_chan.source_pixel[31:24];
         s1_prod_ff  <= s1_prod_in;
         s1_color_ff <= s1_color_in;
         s1_dest_ff  <= req_chan.dest_pixel;
      end
      if (s2_en) s2_word_ff <= s2_word_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_word  = s2_word_ff;

endmodule

### rtl/core/apc_mix.sv
module apc_mix import apc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  apc_mix_type in_word,
   apc_rsp_if.source   rsp_chan
);

   logic        s3_valid_ff;
   apc_sum_type s3_word_ff, s3_word_in;
   logic        s4_valid_ff;
   logic [31:0] s4_pixel_ff, s4_pixel_in;
   logic        s4_written_ff;
   logic        s3_en, s4_en;
   logic [7:0]  inv_alpha;
   logic [2:0][7:0] chan;

   assign s4_en    = !s4_valid_ff || rsp_chan.ready;
   assign s3_en    = !s3_valid_ff || s4_en;
   assign in_ready = s3_en;

   // stage 3: per-channel v*a + d*(255-a) + 128
   always_comb begin
      inv_alpha          = ALPHA_FULL - in_word.alpha;
      s3_word_in.written = in_word.written;
      s3_word_in.dest    = in_word.dest;
      for (int c = 0; c < 3; c++) begin
         s3_word_in.sum[c] = ({8'b0, in_word.color[c*8 +: 8]} * {8'b0, in_word.alpha})
                           + ({8'b0, in_word.dest[c*8 +: 8]} * {8'b0, inv_alpha})
                           + ROUND_BIAS;
      end
   end

   // stage 4: divide by 255; skipped pixels pass the destination through
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         chan[c] = apc_div255(s3_word_ff.sum[c]);
      end
      if (s3_word_ff.written) begin
         s4_pixel_in = {8'h00, chan[2], chan[1], chan[0]};
      end else begin
         s4_pixel_in = s3_word_ff.dest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s3_en) s3_valid_ff <= in_valid;
         if (s4_en) s4_valid_ff <= s3_valid_ff;
      end
      if (s3_en) s3_word_ff <= s3_word_in;
      if (s4_en) begin
         s4_pixel_ff   <= s4_pixel_in;
         s4_written_ff <= s3_word_ff.written;
      end
   end

   assign rsp_chan.valid        = s4_valid_ff;
   assign rsp_chan.result_pixel = s4_pixel_ff;
   assign rsp_chan.written      = s4_written_ff;

endmodule

### rtl/core/argb_pixel_compositor.sv
// Channel   Dir  Handshake        Word
// req_chan  in   valid/ready      mode, source_pixel, dest_pixel
// rsp_chan  out  valid/ready      result_pixel, written
// csr_*     in   csr_write_en     csr_index, csr_write_data (no read-back)
//
// Four register stages: opacity product, blend factor, channel products,
// divide by 255 into the output register. One pixel per cycle unless rsp_chan
// stalls; accepted pixels pass the stages in that order. Reset (synchronous)
// empties the pipe and loads opacity 255, tint black. A stall on rsp_chan
// holds the word in the output register; earlier stages keep filling empty
// slots and req_chan backs off only when every stage holds a word.
module argb_pixel_compositor import apc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   apc_req_if.sink     req_chan,
   apc_rsp_if.source   rsp_chan,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [23:0] csr_write_data
);

   `include "argb_pixel_compositor_assert.svh"

   logic [7:0]  opacity_ff;
   logic [23:0] tint_ff;
   logic        mix_valid;
   logic        mix_ready;
   apc_mix_type mix_word;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         opacity_ff <= OPACITY_RESET;
         tint_ff    <= TINT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_OPACITY: opacity_ff <= csr_write_data[7:0];
            REG_TINT:    tint_ff    <= csr_write_data;
            default:     ;
         endcase
      end
   end

   apc_alpha u_alpha (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .opacity    (opacity_ff),
      .tint_color (tint_ff),
      .out_valid  (mix_valid),
      .out_ready  (mix_ready),
      .out_word   (mix_word)
   );

   apc_mix u_mix (
      .clock    (clock),
      .reset    (reset),
      .in_valid (mix_valid),
      .in_ready (mix_ready),
      .in_word  (mix_word),
      .rsp_chan (rsp_chan)
   );

   // written pixels never carry an alpha byte
   `APC_ASSERT_IMPLIES(a_written_alpha_clear, clock, reset, rsp_chan.valid && rsp_chan.written, rsp_chan.result_pixel[31:24] == 8'h00, "written pixel has nonzero alpha")
   // pipe comes out of reset empty
   `APC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_chan.valid && !mix_valid, "pipeline not empty after reset")
   // opacity write lands in the register
   `APC_ASSERT_NEXT(a_opacity_write, clock, reset, csr_write_en && (csr_index == REG_OPACITY), opacity_ff == $past(csr_write_data[7:0]), "opacity write lost")

endmodule
